### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL. The macros sample on clk and are
// disabled while rst_n is low. Synthesis builds define SYNTH to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication.
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_IMP(label, ante, cons, msg)
`define ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

### rtl/fbfl_pkg.sv
// ----------------------------------------------------------------------------
// fbfl_pkg
// Types and constants of the fixed block free list.
// ----------------------------------------------------------------------------
package fbfl_pkg;

  localparam int SLOTS_DFLT = 256;
  localparam int ALIGN_DFLT = 8;

  localparam int CNT_CFG_W = 9;
  localparam int SIZE_W    = 13;
  localparam int SLOT_W    = 8;
  localparam int OFF_W     = 20;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  localparam logic [CNT_CFG_W-1:0] CNT_RST  = 9'd256;
  localparam logic [SIZE_W-1:0]    SIZE_RST = 13'd8;

  // Action codes of an input item.
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // Register indexes on the configuration port.
  localparam logic REG_SLOT_COUNT = 1'b0;
  localparam logic REG_SLOT_SIZE  = 1'b1;

  typedef struct packed {
    logic              action;
    logic [SLOT_W-1:0] free_slot;
  } fbfl_in_t;

  typedef struct packed {
    logic              granted;
    logic [SLOT_W-1:0] slot;
    logic [OFF_W-1:0]  byte_offset;
    logic              bad_free;
  } fbfl_out_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic load;
  } fbfl_cmd_t;

  typedef struct packed {
    logic out_free;
  } fbfl_stat_t;

endpackage

### rtl/fbfl_ctrl.sv
// ----------------------------------------------------------------------------
// fbfl_ctrl
// Sequencer of the free list: accept, execute against the link memory,
// then hand the result to the output register.
// ----------------------------------------------------------------------------
module fbfl_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  fbfl_pkg::fbfl_stat_t stat,
  output fbfl_pkg::fbfl_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // The next item may start while this result moves to the output.
        if (stat.out_free) begin
          cmd.load   = 1'b1;
          in_ready   = 1'b1;
          cmd.accept = in_valid;
          state_nxt  = in_valid ? ST_EXEC : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/fbfl_dpath.sv
// ----------------------------------------------------------------------------
// fbfl_dpath
// Head pointer, link memory with per-entry valid bits, offset arithmetic
// and the output register of the free list.
// ----------------------------------------------------------------------------
module fbfl_dpath #(
  parameter int SLOTS = fbfl_pkg::SLOTS_DFLT,
  parameter int ALIGN = fbfl_pkg::ALIGN_DFLT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              relink,
  input  logic [fbfl_pkg::CNT_CFG_W-1:0]    slot_count,
  input  logic [fbfl_pkg::SIZE_W-1:0]       slot_size,
  input  fbfl_pkg::fbfl_in_t                in_data,
  input  fbfl_pkg::fbfl_cmd_t               cmd,
  output fbfl_pkg::fbfl_stat_t              stat,
  output logic                              out_valid,
  input  logic                              out_ready,
  output fbfl_pkg::fbfl_out_t               out_data
);

  localparam int IDX_W   = $clog2(SLOTS);
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int CMP_W   = (CNT_W > fbfl_pkg::CNT_CFG_W) ? CNT_W : fbfl_pkg::CNT_CFG_W;
  localparam int N_W     = fbfl_pkg::SIZE_W + 1;
  localparam int SHIFT   = N_W + $clog2(ALIGN);
  localparam int RECIP   = ((1 << SHIFT) + ALIGN - 1) / ALIGN;
  localparam int RECIP_W = N_W + 1;
  localparam int QM_W    = N_W + RECIP_W;
  localparam int PROD_W  = IDX_W + fbfl_pkg::SIZE_W;
  localparam int OFF_W   = fbfl_pkg::OFF_W;
  localparam int SLOT_W  = fbfl_pkg::SLOT_W;

  localparam logic [CNT_W-1:0] END_MARK = CNT_W'(SLOTS);

  // Effective slot count, clamped to the range the pool supports.
  logic [CMP_W-1:0] sc_ext;
  logic [CMP_W-1:0] eff_ext;
  logic [CNT_W-1:0] eff;

  always_comb begin
    sc_ext = CMP_W'(slot_count);
    if (sc_ext < CMP_W'(2)) begin
      eff_ext = CMP_W'(2);
    end else if (sc_ext > CMP_W'(SLOTS)) begin
      eff_ext = CMP_W'(SLOTS);
    end else begin
      eff_ext = sc_ext;
    end
    eff = CNT_W'(eff_ext);
  end

  // Slot size in units of ALIGN, rounded up, by reciprocal multiplication.
  logic [N_W-1:0]               size_up;
  logic [QM_W-1:0]              q_full;
  logic [fbfl_pkg::SIZE_W-1:0]  q_r;

  assign size_up = N_W'(slot_size) + N_W'(ALIGN - 1);
  assign q_full  = QM_W'(size_up) * QM_W'(RECIP);

  always_ff @(posedge clk) begin
    q_r <= fbfl_pkg::SIZE_W'(q_full >> SHIFT);
  end

  // Item registers.
  logic              act_r;
  logic [SLOT_W-1:0] fs_r;
  logic [CNT_W-1:0]  cur_r;
  logic [CNT_W-1:0]  head_r;
  logic [CNT_W-1:0]  head_nxt;

  // Link memory and its valid bits; an entry not written since the last
  // relink reads as the in-order link.
  logic [CNT_W-1:0] link_mem [SLOTS];
  logic [SLOTS-1:0] vld_r;
  logic [CNT_W-1:0] rd_q_r;
  logic             rd_vld_r;

  logic             rd_en;
  logic [IDX_W-1:0] rd_idx;
  logic             hit;
  logic             is_free;
  logic             fs_ok;
  logic [IDX_W-1:0] fs_idx;
  logic [CNT_W-1:0] fs_head;
  logic [CNT_W-1:0] nxt_idx;
  logic [CNT_W-1:0] link_dflt;
  logic [CNT_W-1:0] link_val;
  logic             mem_we;

  assign rd_en     = cmd.accept && (head_r < eff);
  assign rd_idx    = IDX_W'(head_r);
  assign hit       = (act_r == fbfl_pkg::ACT_ALLOC) && (cur_r < eff);
  assign is_free   = (act_r == fbfl_pkg::ACT_FREE);
  assign fs_ok     = CMP_W'(fs_r) < CMP_W'(eff);
  assign fs_idx    = IDX_W'(CMP_W'(fs_r));
  assign fs_head   = CNT_W'(CMP_W'(fs_r));
  assign nxt_idx   = cur_r + CNT_W'(1);
  assign link_dflt = (nxt_idx >= eff) ? END_MARK : nxt_idx;
  assign link_val  = rd_vld_r ? rd_q_r : link_dflt;
  assign mem_we    = cmd.exec && is_free && fs_ok;

  always_comb begin
    head_nxt = head_r;
    if (relink) begin
      head_nxt = '0;
    end else if (cmd.exec && hit) begin
      head_nxt = link_val;
    end else if (mem_we) begin
      head_nxt = fs_head;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
    end else begin
      head_r <= head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || relink) begin
      vld_r <= '0;
    end else if (mem_we) begin
      vld_r[fs_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[fs_idx] <= head_r;
    end
    if (rd_en) begin
      rd_q_r   <= link_mem[rd_idx];
      rd_vld_r <= vld_r[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_r <= in_data.action;
      fs_r  <= in_data.free_slot;
      cur_r <= head_r;
    end
  end

  // Execute: decide the outcome and form the slot product.
  logic [PROD_W-1:0] prod_full;
  logic [OFF_W-1:0]  prod_r;
  logic              grant_r;
  logic              bad_r;

  assign prod_full = PROD_W'(IDX_W'(cur_r)) * PROD_W'(q_r);

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      prod_r  <= OFF_W'(prod_full);
      grant_r <= hit;
      bad_r   <= is_free && !fs_ok;
    end
  end

  // Output register.
  logic                 out_valid_r;
  fbfl_pkg::fbfl_out_t  out_data_r;
  fbfl_pkg::fbfl_out_t  out_nxt;

  always_comb begin
    out_nxt.granted     = grant_r;
    out_nxt.slot        = grant_r ? SLOT_W'(cur_r) : '0;
    out_nxt.byte_offset = grant_r ? prod_r * OFF_W'(ALIGN) : '0;
    out_nxt.bad_free    = bad_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data_r <= out_nxt;
    end
  end

  assign stat.out_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

endmodule

### rtl/fixed_block_free_list.sv
// ----------------------------------------------------------------------------
// fixed_block_free_list
// LIFO free list over a pool of equal-size slots with byte offsets.
// ----------------------------------------------------------------------------
// Each input item either allocates a slot (action 0) or frees the slot named
// in free_slot (action 1), and every item yields exactly one result item.
// An allocation pops the head of the free list and returns the slot index
// and its byte offset, the index times slot_size rounded up to ALIGN; an
// empty pool returns granted 0. A free at or above the slot count, clamped
// to 2..SLOTS, is dropped and reported with bad_free.
// An accepted item passes the execute step, which registers its outcome and
// offset product, and is then loaded into the output register. No new item
// is taken until the last one has executed; the registered read of the link
// memory has to land before the head can move to the next slot.
// A result waiting in the output register does not block the next item; if
// the receiver stalls longer, the block holds the next finished result and
// deasserts in_ready until the output register frees up.
// Reset, and any write of slot_count, links the list in order from slot 0.
// Per-entry valid bits make this take effect at once, with no clearing pass.
// slot_count and slot_size sit at byte addresses 0 and 4 and read back.
// ----------------------------------------------------------------------------
module fixed_block_free_list #(
  parameter int SLOTS = fbfl_pkg::SLOTS_DFLT,
  parameter int ALIGN = fbfl_pkg::ALIGN_DFLT
) (
  input  logic                            clk,
  input  logic                            rst_n,

  input  logic                            in_valid,
  output logic                            in_ready,
  input  fbfl_pkg::fbfl_in_t              in_data,

  output logic                            out_valid,
  input  logic                            out_ready,
  output fbfl_pkg::fbfl_out_t             out_data,

  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fbfl_pkg::ADDR_W-1:0]     paddr,
  input  logic [fbfl_pkg::DATA_W-1:0]     pwdata,
  output logic [fbfl_pkg::DATA_W-1:0]     prdata,
  output logic                            pready
);

  // Configuration registers. Writes complete in the access phase; the
  // register index is the word address.
  logic [fbfl_pkg::CNT_CFG_W-1:0] slot_count_r;
  logic [fbfl_pkg::SIZE_W-1:0]    slot_size_r;
  logic                           cfg_we;
  logic                           reg_idx;
  logic                           relink;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[fbfl_pkg::ADDR_W-1];
  assign relink  = cfg_we && (reg_idx == fbfl_pkg::REG_SLOT_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_count_r <= fbfl_pkg::CNT_RST;
      slot_size_r  <= fbfl_pkg::SIZE_RST;
    end else if (cfg_we) begin
      case (reg_idx)
        fbfl_pkg::REG_SLOT_COUNT: slot_count_r <= fbfl_pkg::CNT_CFG_W'(pwdata);
        fbfl_pkg::REG_SLOT_SIZE:  slot_size_r  <= fbfl_pkg::SIZE_W'(pwdata);
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      fbfl_pkg::REG_SLOT_COUNT: prdata = fbfl_pkg::DATA_W'(slot_count_r);
      fbfl_pkg::REG_SLOT_SIZE:  prdata = fbfl_pkg::DATA_W'(slot_size_r);
      default:                  prdata = '0;
    endcase
  end

  // The sequencer drives the datapath through a small command bundle and
  // learns from it only whether the output register can take a result.
  fbfl_pkg::fbfl_cmd_t  cmd;
  fbfl_pkg::fbfl_stat_t stat;

  fbfl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fbfl_dpath #(
    .SLOTS (SLOTS),
    .ALIGN (ALIGN)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .relink     (relink),
    .slot_count (slot_count_r),
    .slot_size  (slot_size_r),
    .in_data    (in_data),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

`include "assert_macros.svh"

  // An accepted item always goes through the execute step next.
  `ASSERT_NXT(a_accept_exec, in_valid && in_ready, cmd.exec && !in_ready,
              "accepted item did not move to execute")

  // Only one step of an item may be active besides the hand-off overlap.
  `ASSERT_IMP(a_exec_alone, cmd.exec, !cmd.accept && !cmd.load,
              "execute overlapped another step")

  // A result without a grant carries no slot and no offset.
  `ASSERT_IMP(a_no_grant_zero, out_valid && !out_data.granted,
              out_data.slot == '0 && out_data.byte_offset == '0,
              "ungranted result carries slot data")

  // A result is never both a grant and a rejected free.
  `ASSERT_IMP(a_grant_bad_excl, out_valid, !(out_data.granted && out_data.bad_free),
              "granted and bad_free both set")

endmodule

### bench/fbfl_checker.sv
// ----------------------------------------------------------------------------
// fbfl_checker
// Watches the item channels and the register port of the free list, keeps
// its own copy of the list and compares each result item with the oldest
// prediction.
// ----------------------------------------------------------------------------
module fbfl_checker (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  input  logic                          in_ready,
  input  fbfl_pkg::fbfl_in_t            in_data,

  input  logic                          out_valid,
  input  logic                          out_ready,
  input  fbfl_pkg::fbfl_out_t           out_data,

  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fbfl_pkg::ADDR_W-1:0]   paddr,
  input  logic [fbfl_pkg::DATA_W-1:0]   pwdata,
  input  logic                          pready,

  output int                            fail_count,
  output int                            pending,
  output int                            n_grants,
  output int                            n_empty,
  output int                            n_rejected
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HEAD_W   = $clog2(fbfl_pkg::SLOTS_DFLT) + 1;
  localparam int END_MARK = fbfl_pkg::SLOTS_DFLT;

  logic [fbfl_pkg::CNT_CFG_W-1:0] count_reg;
  logic [fbfl_pkg::SIZE_W-1:0]    size_reg;
  logic [HEAD_W-1:0]              free_head;
  logic [HEAD_W-1:0]              next_free [fbfl_pkg::SLOTS_DFLT];
  fbfl_pkg::fbfl_out_t            awaited_results [$];

  // Slot count as the block uses it, clamped to the legal range.
  function automatic int live_slots();
    if (count_reg < 2) return 2;
    if (count_reg > fbfl_pkg::SLOTS_DFLT) return fbfl_pkg::SLOTS_DFLT;
    return int'(count_reg);
  endfunction

  function automatic void relink_pool();
    int n;
    n = live_slots();
    for (int i = 0; i < n - 1; i++) begin
      next_free[i] = HEAD_W'(i + 1);
    end
    next_free[n-1] = HEAD_W'(END_MARK);
    free_head = '0;
  endfunction

  // Pops or pushes the list for one item and returns the result it causes.
  function automatic fbfl_pkg::fbfl_out_t serve_request(fbfl_pkg::fbfl_in_t req);
    fbfl_pkg::fbfl_out_t          res;
    logic [fbfl_pkg::SLOT_W-1:0]  s;
    logic [31:0]                  prod;
    int unsigned                  stride;
    res = '0;
    stride = ((int'(size_reg) + fbfl_pkg::ALIGN_DFLT - 1) / fbfl_pkg::ALIGN_DFLT)
             * fbfl_pkg::ALIGN_DFLT;
    if (req.action == fbfl_pkg::ACT_ALLOC) begin
      if (free_head < live_slots()) begin
        s = free_head[fbfl_pkg::SLOT_W-1:0];
        prod = 32'(s) * stride;
        free_head = next_free[s];
        res.granted = 1'b1;
        res.slot = s;
        res.byte_offset = prod[fbfl_pkg::OFF_W-1:0];
      end
    end else begin
      if (req.free_slot < live_slots()) begin
        next_free[req.free_slot] = free_head;
        free_head = {1'b0, req.free_slot};
      end else begin
        res.bad_free = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic void check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : watch
    fbfl_pkg::fbfl_out_t want;
    fbfl_pkg::fbfl_out_t got;
    if (!rst_n) begin
      count_reg = fbfl_pkg::CNT_RST;
      size_reg = fbfl_pkg::SIZE_RST;
      relink_pool();
      awaited_results.delete();
      fail_count = 0;
      pending = 0;
      n_grants = 0;
      n_empty = 0;
      n_rejected = 0;
    end else begin
      // A result leaves only after its item has passed the execute step, so
      // comparing before predicting at the same edge is safe.
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $error("result item with no prediction waiting: %p", out_data);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("granted", 32'(want.granted), 32'(out_data.granted));
          check_field("slot", 32'(want.slot), 32'(out_data.slot));
          check_field("byte_offset", 32'(want.byte_offset), 32'(out_data.byte_offset));
          check_field("bad_free", 32'(want.bad_free), 32'(out_data.bad_free));
        end
      end
      if (in_valid && in_ready) begin
        got = serve_request(in_data);
        awaited_results.push_back(got);
        if (got.granted) n_grants++;
        else if (in_data.action == fbfl_pkg::ACT_ALLOC) n_empty++;
        if (got.bad_free) n_rejected++;
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[fbfl_pkg::ADDR_W-1:2] == fbfl_pkg::REG_SLOT_COUNT) begin
          count_reg = pwdata[fbfl_pkg::CNT_CFG_W-1:0];
          relink_pool();
        end else begin
          size_reg = pwdata[fbfl_pkg::SIZE_W-1:0];
        end
      end
      pending = awaited_results.size();
    end
  end

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Top of the free list testbench: clock, reset, stimulus and verdict.
// Allocate and free items run through a range of pool sizes and slot sizes
// while both channels idle at random; a separate checker predicts every
// result item and counts mismatches.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Ways the receiver can behave during one stretch of cycles.
  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BEAT} rx_style_t;

  localparam int ITEM_GOAL   = 750;
  localparam int HOLD_CYCLES = 100;

  logic                          clk;
  logic                          rst_n   = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  fbfl_pkg::fbfl_in_t            in_data = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  fbfl_pkg::fbfl_out_t           out_data;
  logic                          psel    = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite  = 1'b0;
  logic [fbfl_pkg::ADDR_W-1:0]   paddr   = '0;
  logic [fbfl_pkg::DATA_W-1:0]   pwdata  = '0;
  logic [fbfl_pkg::DATA_W-1:0]   prdata;
  logic                          pready;

  int fail_count;
  int pending;
  int n_grants;
  int n_empty;
  int n_rejected;

  // Stimulus bookkeeping. live_count mirrors the clamped slot count so that
  // frees can be aimed mostly at slots that exist.
  int useful_items = 0;
  int n_settings   = 0;
  int burst_left   = 0;
  int live_count   = fbfl_pkg::SLOTS_DFLT;
  bit no_gaps      = 1'b0;
  bit hold_toggle  = 1'b0;

  fixed_block_free_list u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  fbfl_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .fail_count (fail_count),
    .pending    (pending),
    .n_grants   (n_grants),
    .n_empty    (n_empty),
    .n_rejected (n_rejected)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Safety net: even the slowest correct run ends far earlier than this.
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // The receiver switches between open stretches, coin-flip stalls, sparse
  // readiness and a fixed beat. When the main sequence flips hold_toggle it
  // holds off while hold_left, loaded from HOLD_CYCLES, counts down, so
  // that the block backs up and has to drop in_ready.
  initial begin : receiver
    rx_style_t style;
    int        left;
    int        hold_left;
    bit        seen_hold;
    style = RX_OPEN;
    left = 0;
    hold_left = 0;
    seen_hold = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_toggle != seen_hold) begin
        seen_hold = hold_toggle;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (left == 0) begin
          style = rx_style_t'($urandom_range(0, 3));
          left = $urandom_range(5, 60);
        end
        left--;
        case (style)
          RX_OPEN:   out_ready <= 1'b1;
          RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
          default:   out_ready <= (left % 3 != 0);
        endcase
      end
    end
  end

  // One register write: setup cycle, then access cycle; the register takes
  // the value at the rising edge inside the access cycle.
  task automatic write_reg(logic idx, logic [fbfl_pkg::DATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    n_settings++;
    if (idx == fbfl_pkg::REG_SLOT_COUNT) begin
      live_count = int'(val[fbfl_pkg::CNT_CFG_W-1:0]);
      if (live_count < 2) live_count = 2;
      else if (live_count > fbfl_pkg::SLOTS_DFLT) live_count = fbfl_pkg::SLOTS_DFLT;
    end
  endtask

  // Offers one item and returns once it has been taken. Items come in bursts;
  // between bursts the channel idles for a random gap with junk on the data.
  task automatic offer(fbfl_pkg::fbfl_in_t item);
    int                  gap;
    fbfl_pkg::fbfl_in_t  junk;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 4);
      if (!no_gaps) begin
        repeat (gap) begin
          junk.action    = 1'($urandom);
          junk.free_slot = fbfl_pkg::SLOT_W'($urandom);
          @(negedge clk);
          in_valid <= 1'b0;
          in_data  <= junk;
        end
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drops valid and waits until every predicted result item has come out.
  // Every item yields a result, so an empty prediction store means idle.
  task automatic quiesce();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // One setting of both registers followed by random items. alloc_pct sets
  // how hard the pool is drained; most frees name a slot that exists.
  task automatic random_phase(logic [fbfl_pkg::CNT_CFG_W-1:0] cnt,
                              logic [fbfl_pkg::SIZE_W-1:0] size,
                              int alloc_pct, int n_items, bit with_hold);
    fbfl_pkg::fbfl_in_t item;
    quiesce();
    write_reg(fbfl_pkg::REG_SLOT_COUNT, {23'($urandom), cnt});
    write_reg(fbfl_pkg::REG_SLOT_SIZE, {19'($urandom), size});
    if (with_hold) begin
      no_gaps = 1'b1;
      hold_toggle <= ~hold_toggle;
    end
    for (int i = 0; i < n_items; i++) begin
      if (with_hold && i == 30) no_gaps = 1'b0;
      if ($urandom_range(0, 99) < alloc_pct) begin
        item = '{fbfl_pkg::ACT_ALLOC, fbfl_pkg::SLOT_W'($urandom)};
      end else if ($urandom_range(0, 99) < 85) begin
        item = '{fbfl_pkg::ACT_FREE, fbfl_pkg::SLOT_W'($urandom_range(0, live_count - 1))};
      end else begin
        item = '{fbfl_pkg::ACT_FREE, fbfl_pkg::SLOT_W'($urandom)};
      end
      offer(item);
      if (!(item.action == fbfl_pkg::ACT_FREE && item.free_slot >= live_count)) begin
        useful_items++;
      end
    end
  endtask

  initial begin : main
    logic [fbfl_pkg::CNT_CFG_W-1:0] cnt;
    logic [fbfl_pkg::SIZE_W-1:0]    size;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset setting: in-order pops, a push of the top
    // slot and an allocate whose free_slot field is ignored.
    offer('{fbfl_pkg::ACT_ALLOC, 8'hFF});
    offer('{fbfl_pkg::ACT_ALLOC, 8'h00});
    offer('{fbfl_pkg::ACT_FREE,  8'd255});
    offer('{fbfl_pkg::ACT_ALLOC, 8'h00});
    offer('{fbfl_pkg::ACT_FREE,  8'd0});
    offer('{fbfl_pkg::ACT_ALLOC, 8'h55});

    // A count of zero is raised to the minimum of two slots; the largest
    // slot size with the pool emptied, frees past the end, and a double
    // free that the block does not catch.
    quiesce();
    write_reg(fbfl_pkg::REG_SLOT_COUNT, 32'd0);
    write_reg(fbfl_pkg::REG_SLOT_SIZE, 32'd8191);
    offer('{fbfl_pkg::ACT_ALLOC, 8'h00});
    offer('{fbfl_pkg::ACT_ALLOC, 8'h00});
    offer('{fbfl_pkg::ACT_ALLOC, 8'h00});
    offer('{fbfl_pkg::ACT_FREE,  8'd2});
    offer('{fbfl_pkg::ACT_FREE,  8'd255});
    offer('{fbfl_pkg::ACT_FREE,  8'd1});
    offer('{fbfl_pkg::ACT_FREE,  8'd1});
    offer('{fbfl_pkg::ACT_ALLOC, 8'h00});
    offer('{fbfl_pkg::ACT_ALLOC, 8'h00});

    // A count above the pool is cut to the full pool. Zero slot size gives
    // zero offsets; a size write then changes offsets but keeps the list.
    quiesce();
    write_reg(fbfl_pkg::REG_SLOT_COUNT, 32'd257);
    write_reg(fbfl_pkg::REG_SLOT_SIZE, 32'd0);
    offer('{fbfl_pkg::ACT_ALLOC, 8'h00});
    offer('{fbfl_pkg::ACT_FREE,  8'd200});
    offer('{fbfl_pkg::ACT_ALLOC, 8'h00});
    quiesce();
    write_reg(fbfl_pkg::REG_SLOT_SIZE, 32'd4096);
    offer('{fbfl_pkg::ACT_ALLOC, 8'h00});
    offer('{fbfl_pkg::ACT_FREE,  8'd255});
    offer('{fbfl_pkg::ACT_ALLOC, 8'h00});
    // The top slot at the widest size overflows the offset field.
    quiesce();
    write_reg(fbfl_pkg::REG_SLOT_SIZE, 32'd8191);
    offer('{fbfl_pkg::ACT_FREE,  8'd255});
    offer('{fbfl_pkg::ACT_ALLOC, 8'h00});

    // Fixed phases cover the extremes: count one, the full pool drained to
    // empty, and a small pool under a long receiver hold-off.
    random_phase(9'd4,   13'd13,   60, 90,  1'b0);
    random_phase(9'd1,   13'd0,    50, 60,  1'b0);
    random_phase(9'd511, 13'd4096, 92, 320, 1'b0);
    random_phase(9'd16,  13'd8191, 55, 100, 1'b1);

    // Random settings, small pools most of the time so the empty and
    // refilled states come up often.
    while (useful_items < ITEM_GOAL) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: cnt = fbfl_pkg::CNT_CFG_W'($urandom_range(2, 12));
        5, 6, 7:       cnt = fbfl_pkg::CNT_CFG_W'($urandom_range(13, 64));
        default:       cnt = fbfl_pkg::CNT_CFG_W'($urandom_range(0, 511));
      endcase
      size = $urandom_range(0, 1) ? fbfl_pkg::SIZE_W'($urandom_range(1, 64))
                                  : fbfl_pkg::SIZE_W'($urandom_range(0, 8191));
      random_phase(cnt, size, $urandom_range(20, 90), $urandom_range(40, 120), 1'b0);
    end

    quiesce();
    // A short wait catches any stray result item.
    repeat (10) @(negedge clk);

    $display("Ran %0d counted items across %0d register writes.", useful_items, n_settings);
    $display("Saw %0d grants, %0d allocations on an empty pool, %0d rejected frees.",
             n_grants, n_empty, n_rejected);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
